@@ rtl/kal_pkg.sv @@
// shared types, constants and fixed point helpers for the attitude estimator
package kal_pkg;

    localparam int FRAC_BITS = 16;
    localparam int AXES      = 3;

    localparam logic [16:0] ONE_U = 17'(1 << FRAC_BITS);
    localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] YAW_LIM  = 64'sd180 <<< FRAC_BITS;
    localparam logic signed [63:0] YAW_FULL = 64'sd360 <<< FRAC_BITS;
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    localparam logic [16:0] SMOOTH_RST = 17'd6554;
    localparam logic [16:0] STEP_RST   = 17'd262;
    localparam logic [30:0] Q_RP_RST   = 31'd131;
    localparam logic [30:0] Q_Y_RST    = 31'd0;
    localparam logic [30:0] R_RST      = 31'd6553600;
    localparam logic signed [31:0] VAR_RST = 32'sd65536;

    localparam int CFG_IDX_W  = 8;
    localparam int DIV_STEPS  = FRAC_BITS + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTHING = 8'd0,
        REG_STEP_TIME = 8'd1,
        REG_Q_ROLL    = 8'd2,
        REG_Q_PITCH   = 8'd3,
        REG_Q_YAW     = 8'd4,
        REG_R_ROLL    = 8'd5,
        REG_R_PITCH   = 8'd6,
        REG_R_YAW     = 8'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_ANG,
        ST_SM1,
        ST_SM2,
        ST_DIV,
        ST_GAIN,
        ST_UPD,
        ST_VAR,
        ST_DONE
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > MAX32)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < MIN32)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
        return (x + HALF_Q) >>> FRAC_BITS;
    endfunction

endpackage

@@ rtl/kal_if.sv @@
// handshake channels: sample in, estimate out, register writes
interface kal_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rate_roll;
    logic signed [31:0] rate_pitch;
    logic signed [31:0] rate_yaw;
    logic signed [31:0] meas_roll;
    logic signed [31:0] meas_pitch;
    logic signed [31:0] meas_yaw;
    modport source (output valid, rate_roll, rate_pitch, rate_yaw, meas_roll, meas_pitch,
                    meas_yaw, input ready);
    modport sink (input valid, rate_roll, rate_pitch, rate_yaw, meas_roll, meas_pitch,
                  meas_yaw, output ready);
endinterface

interface kal_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] est_roll;
    logic signed [31:0] est_pitch;
    logic signed [31:0] est_yaw;
    modport source (output valid, est_roll, est_pitch, est_yaw, input ready);
    modport sink (input valid, est_roll, est_pitch, est_yaw, output ready);
endinterface

interface kal_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/kal_mul.sv @@
// shared signed multiplier with registered product
module kal_mul
(
    input  logic               clk,
    input  logic signed [33:0] a,
    input  logic signed [17:0] b,
    output logic signed [51:0] prod
);

    logic signed [51:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/kal_div.sv @@
// restoring divider for the gain, one quotient bit per cycle
module kal_div
    import kal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [16:0] quot
);

    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg;
    logic [16:0] quot_reg, quot_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    // the numerator is p itself, compared unshifted in the first step, and p never
    // exceeds the denominator, so the quotient is at most one in unsigned Q1.16
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = (cnt_reg == '0) ? rem_reg : {rem_reg[32:0], 1'b0};
        if (start)
        begin
            rem_next  = {2'b00, num};
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ rtl/three_axis_attitude_kalman_top.sv @@
// attitude estimator top: register file, axis sequencer, shared multiplier and divider
//
// sample channel: one item carries three gyro rates and three measured angles,
// all Q16.16. result channel: one item with the three estimated angles per
// sample. cfg channel: index 0..7 selects smoothing, step_time, q_roll,
// q_pitch, q_yaw, r_roll, r_pitch, r_yaw; other indexes are dropped. cfg is
// always ready and should only be written while no sample is in flight.
// the axes are handled one after another by a single 34x18 multiplier and a
// restoring divider that yields one gain bit per cycle. each axis runs seven
// sequencer steps around five multiplies, plus 17 divide steps; an axis whose
// denominator is not positive skips the divide and the correction steps. the
// result is registered after the third axis; the sample channel is ready only
// while the sequencer is idle, not before the last result is loaded.
// a finished result sits in the output register until taken; a stalled
// receiver holds the sequencer in its last step only if the previous result
// is still waiting. reset restores the register defaults, clears the angle
// and smoothed states and sets every variance to one.
module three_axis_attitude_kalman_top
    import kal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kal_in_if.sink    sample,
    kal_out_if.source result,
    kal_cfg_if.sink   cfg
);

    state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    logic [16:0] smooth_reg, step_reg;
    logic [30:0] q_reg [AXES];
    logic [30:0] r_reg [AXES];

    logic signed [31:0] rate_reg [AXES];
    logic signed [31:0] meas_reg [AXES];
    logic signed [31:0] est_reg  [AXES];
    logic signed [31:0] est_next [AXES];
    logic signed [31:0] sm_reg   [AXES];
    logic signed [31:0] sm_next  [AXES];
    logic signed [31:0] var_reg  [AXES];
    logic signed [31:0] var_next [AXES];

    logic signed [31:0] ang_reg, ang_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [32:0] res_reg, res_next;

    logic signed [31:0] out_roll_reg, out_pitch_reg, out_yaw_reg;
    logic               out_valid_reg, out_valid_next, out_load;

    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] mul_prod;
    logic signed [63:0] prod64;

    logic        div_start, div_done;
    logic [16:0] div_quot;
    logic [32:0] div_den;

    logic [16:0]        a_eff;
    logic signed [63:0] sum, wrap;
    logic signed [31:0] s_val, t_val;
    logic signed [33:0] den;

    kal_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(mul_prod));

    kal_div u_div
    (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(p_reg),
        .den(div_den), .done(div_done), .quot(div_quot)
    );

    assign prod64 = 64'(mul_prod);
    assign a_eff  = (smooth_reg > ONE_U) ? ONE_U : smooth_reg;

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= SMOOTH_RST;
            step_reg   <= STEP_RST;
            q_reg[0]   <= Q_RP_RST;
            q_reg[1]   <= Q_RP_RST;
            q_reg[2]   <= Q_Y_RST;
            r_reg[0]   <= R_RST;
            r_reg[1]   <= R_RST;
            r_reg[2]   <= R_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SMOOTHING: smooth_reg <= cfg.data[16:0];
                REG_STEP_TIME: step_reg   <= cfg.data[16:0];
                REG_Q_ROLL:    q_reg[0]   <= cfg.data[30:0];
                REG_Q_PITCH:   q_reg[1]   <= cfg.data[30:0];
                REG_Q_YAW:     q_reg[2]   <= cfg.data[30:0];
                REG_R_ROLL:    r_reg[0]   <= cfg.data[30:0];
                REG_R_PITCH:   r_reg[1]   <= cfg.data[30:0];
                REG_R_YAW:     r_reg[2]   <= cfg.data[30:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                est_reg[i] <= '0;
                sm_reg[i]  <= '0;
                var_reg[i] <= VAR_RST;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < AXES; i++)
            begin
                est_reg[i] <= est_next[i];
                sm_reg[i]  <= sm_next[i];
                var_reg[i] <= var_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
        p_reg   <= p_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        if (sample.valid && sample.ready)
        begin
            rate_reg[0] <= sample.rate_roll;
            rate_reg[1] <= sample.rate_pitch;
            rate_reg[2] <= sample.rate_yaw;
            meas_reg[0] <= sample.meas_roll;
            meas_reg[1] <= sample.meas_pitch;
            meas_reg[2] <= sample.meas_yaw;
        end
        if (out_load)
        begin
            out_roll_reg  <= est_reg[0];
            out_pitch_reg <= est_reg[1];
            out_yaw_reg   <= est_reg[2];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        est_next   = est_reg;
        sm_next    = sm_reg;
        var_next   = var_reg;
        ang_next   = ang_reg;
        p_next     = p_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        mul_a      = 34'(rate_reg[axis_reg]);
        mul_b      = $signed({1'b0, step_reg});
        div_start  = 1'b0;
        out_load   = 1'b0;
        sum        = '0;
        wrap       = '0;
        s_val      = '0;
        t_val      = '0;
        den        = 34'(p_reg) + 34'($signed({1'b0, r_reg[axis_reg]}));
        div_den    = den[32:0];
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            ST_IDLE:
            begin
                axis_next = '0;
                if (sample.valid)
                begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                // prediction product issued, variance grows by process noise
                p_next = sat32(64'(var_reg[axis_reg]) + 64'($signed({1'b0, q_reg[axis_reg]})));
                state_next = ST_ANG;
            end
            ST_ANG:
            begin
                sum = 64'(est_reg[axis_reg]) + rnd(prod64);
                if (axis_reg == 2'd2)
                begin
                    t_val = sat32(sum);
                    wrap  = 64'(t_val);
                    if (wrap > YAW_LIM)
                    begin
                        wrap = wrap - YAW_FULL;
                    end
                    else if (wrap < -YAW_LIM)
                    begin
                        wrap = wrap + YAW_FULL;
                    end
                    ang_next = sat32(wrap);
                end
                else
                begin
                    ang_next = sat32(sum);
                end
                mul_a = 34'(sm_reg[axis_reg]);
                mul_b = $signed({1'b0, ONE_U - a_eff});
                state_next = ST_SM1;
            end
            ST_SM1:
            begin
                acc_next = prod64;
                mul_a = 34'(meas_reg[axis_reg]);
                mul_b = $signed({1'b0, a_eff});
                state_next = ST_SM2;
            end
            ST_SM2:
            begin
                s_val = sat32(rnd(acc_reg + prod64));
                sm_next[axis_reg] = s_val;
                res_next = 33'(s_val) - 33'(ang_reg);
                if (den > 34'sd0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    // no correction without a positive denominator
                    est_next[axis_reg] = ang_reg;
                    var_next[axis_reg] = p_reg;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_RATE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                mul_a = 34'(res_reg);
                mul_b = $signed({1'b0, div_quot});
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ang_next = sat32(64'(ang_reg) + rnd(prod64));
                mul_a = 34'(p_reg);
                mul_b = $signed({1'b0, ONE_U - div_quot});
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                est_next[axis_reg] = ang_reg;
                var_next[axis_reg] = sat32(rnd(prod64));
                if (axis_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_RATE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.valid     = out_valid_reg;
    assign result.est_roll  = out_roll_reg;
    assign result.est_pitch = out_pitch_reg;
    assign result.est_yaw   = out_yaw_reg;

endmodule

@@ bench/kal_checker.sv @@
// checker: watches the sample, result and cfg channels, predicts estimates and compares
`timescale 1ns / 100ps
module kal_checker
    import kal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kal_in_if  sample,
    kal_out_if result,
    kal_cfg_if cfg,
    output int  fail_count,
    output int  pending
);

    typedef struct packed {
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
    } angles_t;

    logic [16:0] smooth_w;
    logic [16:0] dt;
    logic [30:0] q_n [3];
    logic [30:0] r_n [3];
    logic signed [31:0] ang_st [3];
    logic signed [31:0] sm_st [3];
    logic signed [31:0] var_st [3];
    angles_t est_queue [$];

    function automatic logic signed [63:0] round_fx(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + (64'sd1 <<< (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    task automatic predict_sample(input logic signed [31:0] rate [3],
                                  input logic signed [31:0] meas [3]);
        logic signed [63:0] a, ang, p, s, res, den, g, one;
        angles_t e;
        one = 64'sd1 <<< FRAC_BITS;
        a = $signed({47'd0, smooth_w});
        if (a > one)
            a = one;
        for (int i = 0; i < 3; i++)
        begin
            ang = 64'(ang_st[i]) + round_fx(64'(rate[i]) * $signed({47'd0, dt}));
            if (i == 2)
            begin
                ang = clip32(ang);
                if (ang > (64'sd180 <<< FRAC_BITS))
                    ang = ang - (64'sd360 <<< FRAC_BITS);
                else if (ang < -(64'sd180 <<< FRAC_BITS))
                    ang = ang + (64'sd360 <<< FRAC_BITS);
            end
            ang = clip32(ang);
            p = clip32(64'(var_st[i]) + $signed({33'd0, q_n[i]}));
            s = clip32(round_fx((one - a) * 64'(sm_st[i]) + a * 64'(meas[i])));
            sm_st[i] = s[31:0];
            res = s - ang;
            den = p + $signed({33'd0, r_n[i]});
            if (den > 0)
            begin
                g = (p * one) / den;
                ang = clip32(ang + round_fx(g * res));
                p = clip32(round_fx((one - g) * p));
            end
            ang_st[i] = ang[31:0];
            var_st[i] = p[31:0];
        end
        e.roll = ang_st[0];
        e.pitch = ang_st[1];
        e.yaw = ang_st[2];
        est_queue.push_back(e);
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                                 input logic signed [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    assign pending = est_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_w <= SMOOTH_RST;
            dt <= STEP_RST;
            q_n[0] <= Q_RP_RST;
            q_n[1] <= Q_RP_RST;
            q_n[2] <= Q_Y_RST;
            for (int i = 0; i < 3; i++)
            begin
                r_n[i] <= R_RST;
                ang_st[i] <= '0;
                sm_st[i] <= '0;
                var_st[i] <= VAR_RST;
            end
            fail_count <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                angles_t e;
                if (est_queue.size() == 0)
                begin
                    $error("estimate with no sample waiting");
                    fail_count++;
                end
                else
                begin
                    e = est_queue.pop_front();
                    compare_field("est_roll", e.roll, result.est_roll);
                    compare_field("est_pitch", e.pitch, result.est_pitch);
                    compare_field("est_yaw", e.yaw, result.est_yaw);
                end
            end
            if (sample.valid && sample.ready)
            begin
                logic signed [31:0] rt [3];
                logic signed [31:0] ms [3];
                rt[0] = sample.rate_roll;
                rt[1] = sample.rate_pitch;
                rt[2] = sample.rate_yaw;
                ms[0] = sample.meas_roll;
                ms[1] = sample.meas_pitch;
                ms[2] = sample.meas_yaw;
                predict_sample(rt, ms);
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SMOOTHING: smooth_w = cfg.data[16:0];
                    REG_STEP_TIME: dt = cfg.data[16:0];
                    REG_Q_ROLL:    q_n[0] = cfg.data[30:0];
                    REG_Q_PITCH:   q_n[1] = cfg.data[30:0];
                    REG_Q_YAW:     q_n[2] = cfg.data[30:0];
                    REG_R_ROLL:    r_n[0] = cfg.data[30:0];
                    REG_R_PITCH:   r_n[1] = cfg.data[30:0];
                    REG_R_YAW:     r_n[2] = cfg.data[30:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ bench/tb_three_axis_attitude_kalman_top.sv @@
// testbench top: clock, reset, sample and register stimulus, verdict
`timescale 1ns / 100ps
module tb_three_axis_attitude_kalman_top
    import kal_pkg::*;
();

    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   calm = 1'b0;

    kal_in_if  sample ();
    kal_out_if result ();
    kal_cfg_if cfg ();

    three_axis_attitude_kalman_top dut (.clk(clk), .rst_n(rst_n), .sample(sample),
        .result(result), .cfg(cfg));

    kal_checker chk (.clk(clk), .rst_n(rst_n), .sample(sample), .result(result),
        .cfg(cfg), .fail_count(fail_count), .pending(pending));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random, except in the calm stretch
    always @(negedge clk)
        result.ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);

    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value(input int mode);
        logic signed [31:0] v;
        case ($urandom_range(9))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2, 3: v = $urandom;
            default: v = $signed($urandom_range(mode)) - $signed(mode / 2);
        endcase
        return v;
    endfunction

    task automatic send_sample(input logic signed [31:0] r0, r1, r2, m0, m1, m2);
        // valid goes low between items, and stays low longer at random outside the calm stretch
        do
            @(negedge clk);
        while (!calm && $urandom_range(99) < 23);
        sample.valid <= 1'b1;
        sample.rate_roll <= r0;
        sample.rate_pitch <= r1;
        sample.rate_yaw <= r2;
        sample.meas_roll <= m0;
        sample.meas_pitch <= m1;
        sample.meas_yaw <= m2;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        @(negedge clk);
        sample.valid <= 1'b0;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
    endtask

    task automatic random_settings(input int extreme);
        write_reg(REG_SMOOTHING, extreme == 1 ? 32'd0 :
                  extreme == 2 ? 32'h1ffff : {15'd0, 17'($urandom_range(65536))});
        write_reg(REG_STEP_TIME, extreme == 1 ? 32'd0 :
                  extreme == 2 ? 32'h1ffff : {15'd0, 17'($urandom_range(65536))});
        for (int i = 0; i < 3; i++)
        begin
            write_reg(cfg_reg_t'(REG_Q_ROLL + i), extreme == 1 ? 32'd0 :
                      extreme == 2 ? 32'hffffffff : $urandom_range(200000));
            write_reg(cfg_reg_t'(REG_R_ROLL + i), extreme == 1 ? 32'd1 :
                      extreme == 2 ? 32'h7fffffff : 32'($urandom_range(100000000, 1)));
        end
    endtask

    initial
    begin
        sample.valid = 1'b0;
        sample.rate_roll = '0;
        sample.rate_pitch = '0;
        sample.rate_yaw = '0;
        sample.meas_roll = '0;
        sample.meas_pitch = '0;
        sample.meas_yaw = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: defaults, extremes, yaw wrap both ways
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                    32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_sample(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                    32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        drain();
        write_reg(REG_SMOOTHING, 32'd65536);
        write_reg(REG_STEP_TIME, 32'd65536);
        repeat (4)
            send_sample(0, 0, 32'sd100 <<< 16, 0, 0, 32'sd170 <<< 16);
        repeat (4)
            send_sample(0, 0, -(32'sd100 <<< 16), 0, 0, -(32'sd170 <<< 16));
        drain();
        random_settings(2);
        repeat (4)
            send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        drain();
        random_settings(1);
        write_reg(cfg_reg_t'(8'd9), 32'hffffffff);
        repeat (4)
            send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            random_settings(ph == 3 ? 2 : 0);
            calm = (ph == 5);
            for (int n = 0; n < 150; n++)
            begin
                if (n == 75)
                    drain();
                send_sample(pick_value(400 << 16), pick_value(400 << 16),
                            pick_value(400 << 16), pick_value(360 << 16),
                            pick_value(360 << 16), pick_value(500 << 16));
            end
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kal_pkg.sv
rtl/kal_if.sv
rtl/kal_mul.sv
rtl/kal_div.sv
rtl/three_axis_attitude_kalman_top.sv
bench/kal_checker.sv
bench/tb_three_axis_attitude_kalman_top.sv
